FILE: design/stm_pkg.sv
// Shared constants, codes, control/status structs and helpers for the range-minimum engine.
package stm_pkg;

    // Sizing
    localparam int MAX_ELEMENTS = 1024;
    localparam int LEVELS       = 11;
    localparam int VALUE_BITS   = 32;

    localparam int IDX_W     = $clog2(MAX_ELEMENTS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int SPAN_W    = CNT_W + 1;
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int LOG_W     = $clog2(CNT_W);
    localparam int TBL_AW    = LVL_W + IDX_W;
    localparam int TBL_DEPTH = (LEVELS - 1) * MAX_ELEMENTS;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;

    // Command codes of an input item
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd_code;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_RANGE     = 2'd1,
        STS_NOT_BUILT = 2'd2
    } t_status;

    // Result kinds
    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_BRD,
        S_BEL,
        S_BWR,
        S_BEMIT,
        S_QRD,
        S_QEL,
        S_QEMIT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic pos_rd;
        logic pos_query;
        logic elem_rd;
        logic tbl_wr;
        logic emit_build;
        logic emit_query;
    } t_ctrl;

    // Status from datapath to controller
    typedef struct packed {
        logic first_level_ok;
        logic last_entry;
        logic next_level_ok;
        logic q_err;
        logic out_free;
    } t_stat;

    // Floor of log2 by priority encoding the highest set bit
    function automatic logic [LOG_W-1:0] floor_log2(input logic [CNT_W-1:0] x);
        logic [LOG_W-1:0] r;
        r = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (x[i]) begin
                r = LOG_W'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: design/stm_if.sv
// Channel interfaces: command input, result output and element count write.
interface stm_in_if;
    import stm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CMD_W-1:0]      cmd;
    logic [IDX_W-1:0]      index;
    logic [VALUE_BITS-1:0] value;
    logic [IDX_W-1:0]      query_low;
    logic [IDX_W-1:0]      query_high;

    modport source (output valid, cmd, index, value, query_low, query_high, input ready);
    modport sink   (input valid, cmd, index, value, query_low, query_high, output ready);
endinterface

interface stm_out_if;
    import stm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [IDX_W-1:0]      min_position;
    logic [VALUE_BITS-1:0] min_value;
    logic [STATUS_W-1:0]   status;

    modport source (output valid, kind, min_position, min_value, status, input ready);
    modport sink   (input valid, kind, min_position, min_value, status, output ready);
endinterface

interface stm_cfg_if;
    import stm_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] element_count;

    modport source (output valid, element_count, input ready);
    modport sink   (input valid, element_count, output ready);
endinterface

FILE: design/stm_ctrl.sv
// Controller state machine sequencing loads, table build and range queries.
module stm_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic [stm_pkg::CMD_W-1:0] i_in_cmd,
    input  stm_pkg::t_stat          i_stat,
    output stm_pkg::t_ctrl          o_ctrl,
    output logic                    o_in_ready
);
    import stm_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_cmd)
                        CMD_BUILD: n_state = i_stat.first_level_ok ? S_BRD : S_BEMIT;
                        CMD_QUERY: n_state = S_QRD;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_BRD: n_state = S_BEL;
            S_BEL: n_state = S_BWR;
            S_BWR: begin
                if (i_stat.last_entry) begin
                    n_state = i_stat.next_level_ok ? S_BRD : S_BEMIT;
                end else begin
                    n_state = S_BRD;
                end
            end
            S_BEMIT: n_state = i_stat.out_free ? S_IDLE : S_BEMIT;
            S_QRD:   n_state = i_stat.q_err ? S_QEMIT : S_QEL;
            S_QEL:   n_state = S_QEMIT;
            S_QEMIT: n_state = i_stat.out_free ? S_IDLE : S_QEMIT;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_ctrl.accept = i_in_valid;
            end
            S_BRD:   o_ctrl.pos_rd = 1'b1;
            S_BEL:   o_ctrl.elem_rd = 1'b1;
            S_BWR:   o_ctrl.tbl_wr = 1'b1;
            S_BEMIT: o_ctrl.emit_build = i_stat.out_free;
            S_QRD: begin
                o_ctrl.pos_rd    = 1'b1;
                o_ctrl.pos_query = 1'b1;
            end
            S_QEL:   o_ctrl.elem_rd = 1'b1;
            S_QEMIT: o_ctrl.emit_query = i_stat.out_free;
            default: o_ctrl = '0;
        endcase
    end

endmodule

FILE: design/stm_dpath.sv
// Datapath: element and position memories, build counters, compare unit, result register.
module stm_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  stm_pkg::t_ctrl                 i_ctrl,
    output stm_pkg::t_stat                 o_stat,
    input  logic [stm_pkg::CMD_W-1:0]      i_cmd,
    input  logic [stm_pkg::IDX_W-1:0]      i_index,
    input  logic [stm_pkg::VALUE_BITS-1:0] i_value,
    input  logic [stm_pkg::IDX_W-1:0]      i_query_low,
    input  logic [stm_pkg::IDX_W-1:0]      i_query_high,
    stm_cfg_if.sink                        i_cfg,
    stm_out_if.source                      o_out
);
    import stm_pkg::*;

    // Configuration and table state
    logic [CNT_W-1:0] r_count;
    logic             r_ready;
    logic [CNT_W-1:0] n_act;

    // Latched query range
    logic [IDX_W-1:0] r_lo;
    logic [IDX_W-1:0] r_hi;

    // Build counters
    logic [LVL_W-1:0] r_lvl;
    logic [IDX_W-1:0] r_ent;

    // Memories
    logic [VALUE_BITS-1:0] r_elem_mem [0:MAX_ELEMENTS-1];
    logic [IDX_W-1:0]      r_tbl_mem  [0:TBL_DEPTH-1];

    // Position read stage
    logic             r_virt;
    logic [IDX_W-1:0] r_ia;
    logic [IDX_W-1:0] r_ib;
    logic [IDX_W-1:0] r_ma;
    logic [IDX_W-1:0] r_mb;
    logic [IDX_W-1:0] pos_a;
    logic [IDX_W-1:0] pos_b;

    // Element read stage
    logic [IDX_W-1:0]      r_pa;
    logic [IDX_W-1:0]      r_pb;
    logic [VALUE_BITS-1:0] r_va;
    logic [VALUE_BITS-1:0] r_vb;
    logic [IDX_W-1:0]      win_pos;
    logic [VALUE_BITS-1:0] win_val;

    // Result register
    logic                  r_out_valid;
    logic                  r_kind;
    logic [IDX_W-1:0]      r_min_pos;
    logic [VALUE_BITS-1:0] r_min_val;
    t_status               r_status;

    // Address generation
    logic [SPAN_W-1:0] span;
    logic [SPAN_W-1:0] half;
    logic [CNT_W-1:0]  q_len;
    logic [LOG_W-1:0]  q_log;
    logic [LVL_W-1:0]  q_lvl;
    logic [SPAN_W-1:0] q_span;
    logic [IDX_W-1:0]  q_start_b;
    t_status           q_status;
    logic [LVL_W-1:0]  rd_lvl;
    logic [IDX_W-1:0]  rd_a;
    logic [IDX_W-1:0]  rd_b;
    logic [LVL_W-1:0]  tbl_lvl;
    logic              load_we;
    logic              cfg_we;

    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;

    // Clamp the element count to 1..MAX_ELEMENTS
    always_comb begin
        n_act = r_count;
        if (r_count == '0) begin
            n_act = CNT_W'(1);
        end else if (r_count > CNT_W'(MAX_ELEMENTS)) begin
            n_act = CNT_W'(MAX_ELEMENTS);
        end
    end

    assign load_we = i_ctrl.accept && (i_cmd == CMD_LOAD) && (CNT_W'(i_index) < n_act);

    // Build level geometry
    assign span = SPAN_W'(1) << r_lvl;
    assign half = span >> 1;

    // Query level and second window start
    assign q_len = CNT_W'(r_hi) - CNT_W'(r_lo) + CNT_W'(1);
    assign q_log = floor_log2(q_len);
    always_comb begin
        if (int'(q_log) > LEVELS - 1) begin
            q_lvl = LVL_W'(LEVELS - 1);
        end else begin
            q_lvl = LVL_W'(q_log);
        end
    end
    assign q_span    = SPAN_W'(1) << q_lvl;
    assign q_start_b = IDX_W'(SPAN_W'(r_hi) + SPAN_W'(1) - q_span);

    // Query check: not built first, then range
    always_comb begin
        if (!r_ready) begin
            q_status = STS_NOT_BUILT;
        end else if ((r_lo > r_hi) || (CNT_W'(r_hi) >= n_act)) begin
            q_status = STS_RANGE;
        end else begin
            q_status = STS_OK;
        end
    end

    // Status to controller
    always_comb begin
        o_stat.first_level_ok = (LEVELS > 1) && (n_act >= CNT_W'(2));
        o_stat.last_entry     = (SPAN_W'(r_ent) + span) == SPAN_W'(n_act);
        o_stat.next_level_ok  = ((int'(r_lvl) + 1) < LEVELS) && ((span << 1) <= SPAN_W'(n_act));
        o_stat.q_err          = (q_status != STS_OK);
        o_stat.out_free       = !r_out_valid || o_out.ready;
    end

    // Position read addresses: query windows or the two halves of a build window
    assign rd_lvl  = i_ctrl.pos_query ? q_lvl : (r_lvl - LVL_W'(1));
    assign rd_a    = i_ctrl.pos_query ? r_lo : r_ent;
    assign rd_b    = i_ctrl.pos_query ? q_start_b : IDX_W'(SPAN_W'(r_ent) + half);
    assign tbl_lvl = rd_lvl - LVL_W'(1);

    // Level zero is the identity and is not stored
    assign pos_a = r_virt ? r_ia : r_ma;
    assign pos_b = r_virt ? r_ib : r_mb;

    // Pick the smaller value; ties go to the second candidate
    assign win_pos = ($signed(r_va) < $signed(r_vb)) ? r_pa : r_pb;
    assign win_val = ($signed(r_va) < $signed(r_vb)) ? r_va : r_vb;

    // Element memory: load write, two reads
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_elem_mem[i_index] <= i_value;
        end
        if (i_ctrl.elem_rd) begin
            r_va <= r_elem_mem[pos_a];
            r_vb <= r_elem_mem[pos_b];
            r_pa <= pos_a;
            r_pb <= pos_b;
        end
    end

    // Position table memory: build write, two reads
    always_ff @(posedge i_clk) begin
        if (i_ctrl.tbl_wr) begin
            r_tbl_mem[TBL_AW'({r_lvl - LVL_W'(1), r_ent})] <= win_pos;
        end
        if (i_ctrl.pos_rd) begin
            r_virt <= (rd_lvl == '0);
            r_ia   <= rd_a;
            r_ib   <= rd_b;
            if (rd_lvl != '0) begin
                r_ma <= r_tbl_mem[TBL_AW'({tbl_lvl, rd_a})];
                r_mb <= r_tbl_mem[TBL_AW'({tbl_lvl, rd_b})];
            end
        end
    end

    // Latch the query range on accept
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_lo <= i_query_low;
            r_hi <= i_query_high;
        end
    end

    // Count register, table-ready flag, build counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CNT_W'(MAX_ELEMENTS);
            r_ready <= 1'b0;
            r_lvl   <= '0;
            r_ent   <= '0;
        end else begin
            if (cfg_we) begin
                r_count <= i_cfg.element_count;
            end
            if (cfg_we || load_we) begin
                r_ready <= 1'b0;
            end else if (i_ctrl.emit_build) begin
                r_ready <= 1'b1;
            end
            if (i_ctrl.accept) begin
                r_lvl <= LVL_W'(1);
                r_ent <= '0;
            end else if (i_ctrl.tbl_wr) begin
                if (o_stat.last_entry) begin
                    r_lvl <= r_lvl + LVL_W'(1);
                    r_ent <= '0;
                end else begin
                    r_ent <= r_ent + IDX_W'(1);
                end
            end
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.emit_build || i_ctrl.emit_query) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit_build) begin
            r_kind    <= KIND_BUILD;
            r_min_pos <= '0;
            r_min_val <= '0;
            r_status  <= STS_OK;
        end else if (i_ctrl.emit_query) begin
            r_kind   <= KIND_QUERY;
            r_status <= q_status;
            if (q_status == STS_OK) begin
                r_min_pos <= win_pos;
                r_min_val <= win_val;
            end else begin
                r_min_pos <= '0;
                r_min_val <= '0;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_kind;
    assign o_out.min_position = r_min_pos;
    assign o_out.min_value    = r_min_val;
    assign o_out.status       = r_status;

endmodule

FILE: design/sparse_table_range_min.sv
// Top level of the sparse-table range-minimum engine.
//
//  channel  | dir | handshake       | payload
//  i_in     | in  | valid / ready   | cmd, index, value, query_low, query_high
//  o_out    | out | valid / ready   | kind, min_position, min_value, status
//  i_cfg    | in  | valid / ready   | element_count
//
// A load or an unused command is taken in the idle state; a query runs the position-table
// read, element read and compare steps in sequence (a flagged query skips the element read).
// A build fills the n - 2^k + 1 entries of each level k >= 1 with 2^k <= n, one entry
// at a time through the shared read-compare-write unit; no new item is taken meanwhile.
// Reset is synchronous, active low; no clearing pass is run, both memories start unwritten.
// A result that is not taken stalls the engine in its final step; i_cfg is always ready.
module sparse_table_range_min (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stm_in_if.sink    i_in,
    stm_cfg_if.sink   i_cfg,
    stm_out_if.source o_out
);
    import stm_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    // Sequencer
    stm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .i_stat     (stat),
        .o_ctrl     (ctrl),
        .o_in_ready (i_in.ready)
    );

    // Storage and compare unit
    stm_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .o_stat       (stat),
        .i_cmd        (i_in.cmd),
        .i_index      (i_in.index),
        .i_value      (i_in.value),
        .i_query_low  (i_in.query_low),
        .i_query_high (i_in.query_high),
        .i_cfg        (i_cfg),
        .o_out        (o_out)
    );

endmodule

FILE: design/stm_checker.sv
// Port-level checker for the range-minimum engine and its bind to the top level.
module stm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic [stm_pkg::CMD_W-1:0]      i_in_cmd,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_out_kind,
    input logic [stm_pkg::IDX_W-1:0]      i_out_pos,
    input logic [stm_pkg::VALUE_BITS-1:0] i_out_value,
    input logic [stm_pkg::STATUS_W-1:0]   i_out_status
);
    import stm_pkg::*;

    // A build or query item occupies the engine on the next cycle
    a_busy_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_cmd == CMD_BUILD || i_in_cmd == CMD_QUERY))
        |=> !i_in_ready)
        else $error("engine ready right after a build or query item");

    // After a load the engine is ready again on the next cycle
    a_load_single_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_cmd == CMD_LOAD) |=> i_in_ready)
        else $error("engine not ready after a load item");

    // Build-done results carry zero fields and ok status
    a_build_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_kind == KIND_BUILD)
        |-> (i_out_status == STS_OK && i_out_pos == '0 && i_out_value == '0))
        else $error("build-done item with nonzero fields");

    // Flagged results are query answers with zero fields
    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status != STS_OK)
        |-> (i_out_kind == KIND_QUERY && i_out_pos == '0 && i_out_value == '0))
        else $error("flagged item with nonzero fields");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready)
        |=> (i_out_valid && $stable(i_out_pos) && $stable(i_out_value)))
        else $error("result item changed while stalled");

endmodule

bind sparse_table_range_min stm_checker u_stm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_cmd     (i_in.cmd),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_kind   (o_out.kind),
    .i_out_pos    (o_out.min_position),
    .i_out_value  (o_out.min_value),
    .i_out_status (o_out.status)
);
